/* rtl/lookahead_token_recognizer_macros.svh */
// assertion macros for the lookahead token recognizer
`ifndef LOOKAHEAD_TOKEN_RECOGNIZER_MACROS_SVH
`define LOOKAHEAD_TOKEN_RECOGNIZER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define LTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lookahead token recognizer check failed");
// next-cycle implication, checked at every rising edge outside reset
`define LTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lookahead token recognizer check failed");
`else
`define LTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ltr_pkg.sv */
// shared types, codes and character classes of the lookahead token recognizer
`timescale 1ns / 1ps

package ltr_pkg;

  // scan modes
  localparam logic [1:0] MODE_DECL = 2'd0;
  localparam logic [1:0] MODE_STAR = 2'd1;
  localparam logic [1:0] MODE_NONE = 2'd2;

  // scan phases
  localparam logic [1:0] PH_SKIP1 = 2'd0;
  localparam logic [1:0] PH_IDENT = 2'd1;
  localparam logic [1:0] PH_SKIP2 = 2'd2;

  // comment tracking states
  localparam logic [2:0] CS_PLAIN = 3'd0;
  localparam logic [2:0] CS_DASH  = 3'd1;
  localparam logic [2:0] CS_LINE  = 3'd2;
  localparam logic [2:0] CS_SLASH = 3'd3;
  localparam logic [2:0] CS_BLOCK = 3'd4;
  localparam logic [2:0] CS_BSTAR = 3'd5;

  // character codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // one input beat
  typedef struct packed {
    logic       at_end;
    logic [7:0] char_code;
    logic [1:0] mode;
    logic       start_req;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [1:0] token_kind;
    logic       matched;
  } result_t;

  // scan state seen from outside the scanner
  typedef struct packed {
    logic       active;
    logic [1:0] mode;
    logic [1:0] phase;
  } scan_status_t;

  function automatic logic id_first(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

  function automatic logic id_rest(input logic [7:0] c);
    return id_first(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

/* rtl/lookahead_token_recognizer.sv */
// Lookahead token recognizer, top level
// Takes one character per beat on the slave stream: tdata carries the byte,
// tuser carries start_req, mode and at_end. A start beat opens a scan in
// declarator, same-line star or none mode; blanks, newlines, line comments
// and block comments are skipped. When a scan decides, one beat leaves on
// the master stream with the match flag in tdata and the mode in tuser.
// Beats that arrive while no scan is open give no result.
// Path: an accepted beat is held in the input register, judged there
// against the scan state, and its result is written to the result register.
// Throughput: one character per cycle while no deciding beat is stalled;
// the per-character step is a single pass of state logic between the
// input register and the result register. Stall: the input register keeps
// accepting while a result waits, until it holds a beat that would decide;
// that beat waits for a free result register; beats deciding nothing flow.
// Reset: clears the input and result valid flags and returns the scanner
// to idle, with no scan open.
`timescale 1ns / 1ps
`include "lookahead_token_recognizer_macros.svh"

module lookahead_token_recognizer
  import ltr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic [3:0] s_axis_tuser_i,   // [0] start_req, [2:1] mode, [3] at_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] matched, [7:1] zero
  output logic [1:0] m_axis_tuser_o    // [1:0] token_kind
);

  logic         in_valid_q;
  item_t        in_q;
  logic         step_en;
  logic         res_valid;
  result_t      res;
  logic         out_free;
  scan_status_t status;

  // step the scanner unless a decision would find the result slot full
  assign step_en         = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready_o = !in_valid_q || step_en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.start_req <= s_axis_tuser_i[0];
      in_q.mode      <= s_axis_tuser_i[2:1];
      in_q.at_end    <= s_axis_tuser_i[3];
      in_q.char_code <= s_axis_tdata_i;
    end
  end

  ltr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  ltr_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (step_en && res_valid),
    .wr_data_i       (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // a decision never overwrites a result still waiting
  `LTR_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, step_en && res_valid, out_free)
  // a decided scan closes
  `LTR_ASSERT_NEXT(a_decide_closes, clk_i, rst_ni, step_en && res_valid, !status.active)
  // only declarator scans leave the first skip phase
  `LTR_ASSERT_NOW(a_phase_mode, clk_i, rst_ni, status.active && status.phase != PH_SKIP1,
                  status.mode == MODE_DECL)
  // a decision puts a beat on the master side
  `LTR_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, step_en && res_valid, m_axis_tvalid_o)

endmodule

/* rtl/ltr_scan.sv */
// scan state registers and the per-character step logic
`timescale 1ns / 1ps

module ltr_scan
  import ltr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_en_i,
  input  item_t        item_i,
  output logic         res_valid_o,
  output result_t      res_o,
  output scan_status_t status_o
);

  logic       active_q, active_d;
  logic [1:0] mode_q, mode_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] cs_q, cs_d;
  logic       nl_q, nl_d;

  logic       decide;
  logic       match;
  logic       do_skip;
  logic       do_judge;
  logic [7:0] c;
  logic       eof;

  assign c   = item_i.char_code;
  assign eof = item_i.at_end;

  // next state and decision for the item in the input register
  always_comb begin
    active_d = active_q;
    mode_d   = mode_q;
    phase_d  = phase_q;
    cs_d     = cs_q;
    nl_d     = nl_q;
    decide   = 1'b0;
    match    = 1'b0;
    do_skip  = 1'b0;
    do_judge = 1'b0;

    // start beat restarts the scan, mode three folds into none
    if (item_i.start_req) begin
      active_d = 1'b1;
      mode_d   = item_i.mode[1] ? MODE_NONE : item_i.mode;
      phase_d  = PH_SKIP1;
      cs_d     = CS_PLAIN;
      nl_d     = 1'b0;
    end

    if (active_d) begin
      if (mode_d == MODE_NONE) begin
        decide = 1'b1;
      end else begin
        do_skip = 1'b1;
        // identifier body
        if (mode_d == MODE_DECL && phase_d == PH_IDENT) begin
          if (eof) begin
            decide  = 1'b1;
            do_skip = 1'b0;
          end else if (id_rest(c)) begin
            do_skip = 1'b0;
          end else begin
            phase_d = PH_SKIP2;
            cs_d    = CS_PLAIN;
          end
        end

        // blank and comment skipping
        if (do_skip) begin
          if (eof) begin
            decide = 1'b1;
          end else begin
            unique case (cs_d) inside
              CS_DASH: begin
                if (c == CH_DASH) begin
                  cs_d = CS_LINE;
                end else begin
                  cs_d     = CS_PLAIN;
                  do_judge = 1'b1;
                end
              end
              CS_LINE: begin
                if (c == CH_LF) begin
                  nl_d = 1'b1;
                  cs_d = CS_PLAIN;
                end
              end
              CS_SLASH: begin
                if (c == CH_STAR) begin
                  cs_d = CS_BLOCK;
                end else begin
                  cs_d     = CS_PLAIN;
                  do_judge = 1'b1;
                end
              end
              CS_BLOCK, CS_BSTAR: begin
                if (cs_d == CS_BSTAR && c == CH_SLASH) begin
                  cs_d = CS_PLAIN;
                end else begin
                  if (c == CH_LF || c == CH_CR) begin
                    nl_d = 1'b1;
                  end
                  cs_d = (c == CH_STAR) ? CS_BSTAR : CS_BLOCK;
                end
              end
              default: begin
                cs_d = CS_PLAIN;
                if (c == CH_LF || c == CH_CR) begin
                  nl_d = 1'b1;
                end else if (c == CH_SP || c == CH_TAB) begin
                  cs_d = CS_PLAIN;
                end else if (c == CH_DASH) begin
                  cs_d = CS_DASH;
                end else if (c == CH_SLASH) begin
                  cs_d = CS_SLASH;
                end else begin
                  do_judge = 1'b1;
                end
              end
            endcase
          end
        end

        // judge the first character after a skip
        if (do_judge) begin
          if (mode_d == MODE_STAR) begin
            decide = 1'b1;
            match  = (c == CH_STAR) && !nl_d;
          end else if (phase_d == PH_SKIP1) begin
            if (id_first(c)) begin
              phase_d = PH_IDENT;
            end else begin
              decide = 1'b1;
            end
          end else begin
            decide = 1'b1;
            match  = (c == CH_COMMA) || (c == CH_COLON);
          end
        end
      end

      if (decide) begin
        active_d = 1'b0;
      end
    end
  end

  assign res_valid_o      = decide;
  assign res_o.matched    = match;
  assign res_o.token_kind = mode_d;

  assign status_o.active = active_q;
  assign status_o.mode   = mode_q;
  assign status_o.phase  = phase_q;

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mode_q   <= MODE_DECL;
      phase_q  <= PH_SKIP1;
      cs_q     <= CS_PLAIN;
      nl_q     <= 1'b0;
    end else if (step_en_i) begin
      active_q <= active_d;
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      cs_q     <= cs_d;
      nl_q     <= nl_d;
    end
  end

endmodule

/* rtl/ltr_out_reg.sv */
// result register driving the master-side stream
`timescale 1ns / 1ps

module ltr_out_reg
  import ltr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  result_t    wr_data_i,
  output logic       free_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [0] matched, [7:1] zero
  output logic [1:0] m_axis_tuser_o   // [1:0] token_kind
);

  logic    valid_q;
  result_t data_q;

  // slot can take a new beat when empty or draining this cycle
  assign free_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= wr_en_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (free_o && wr_en_i) begin
      data_q <= wr_data_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {7'b0, data_q.matched};
  assign m_axis_tuser_o  = data_q.token_kind;

endmodule
